### rtl/cks_pkg.sv
`timescale 1ns / 1ps

package cks_pkg;

	localparam int MAX_LINE_WIDTH = 2048;
	localparam int PIXEL_CHANNELS = 3;
	localparam int CHAN_W         = 8;
	localparam int PX_W           = CHAN_W * PIXEL_CHANNELS;
	localparam int ADDR_W         = $clog2(MAX_LINE_WIDTH);
	localparam int ROW_W          = 12;
	localparam int COL_W          = 11;
	localparam int CFG_W          = 12;
	localparam int TUSER_W        = 2;
	localparam int OUT_TDATA_W    = ((PX_W + ROW_W + COL_W + 7) / 8) * 8;
	localparam int SHARP_GAIN     = 5;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

	// configuration register indexes
	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// tuser bits on the input side
	localparam int TUSER_SOF   = 0;
	localparam int TUSER_FLUSH = 1;

	// where a result's pixel comes from
	typedef enum logic [1:0] {
		SRC_WINDOW,
		SRC_SHARP,
		SRC_UP,
		SRC_MID
	} cks_src_t;

	typedef struct packed {
		logic             sharp;
		logic [PX_W-1:0]  pass_px;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             eof;
	} cks_res_t;

endpackage

### rtl/cks_line_store.sv
`timescale 1ns / 1ps

module cks_line_store
	import cks_pkg::*;
(
	input  logic                clk,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [2*PX_W-1:0]   wr_data,
	output logic [2*PX_W-1:0]   rd_data
);

	// entry: middle row pixel high, upper row pixel low
	logic [2*PX_W-1:0] mem [MAX_LINE_WIDTH];
	logic [2*PX_W-1:0] rd_q;
	logic [2*PX_W-1:0] byp_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr_data;
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? byp_q : rd_q;

endmodule

### rtl/cks_lane.sv
`timescale 1ns / 1ps

module cks_lane
	import cks_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [CHAN_W-1:0] centre,
	input  logic [CHAN_W-1:0] left,
	input  logic [CHAN_W-1:0] right,
	input  logic [CHAN_W-1:0] up,
	input  logic [CHAN_W-1:0] down,
	output logic [CHAN_W-1:0] sharp_s2
);

	localparam int SUM_W = CHAN_W + 4;

	logic signed [SUM_W-1:0] gain;
	logic signed [SUM_W-1:0] ring;
	logic signed [SUM_W-1:0] diff;
	logic [CHAN_W-1:0]       clamped;

	always_comb begin
		gain = SUM_W'(centre) * SUM_W'(SHARP_GAIN);
		ring = SUM_W'(left) + SUM_W'(right) + SUM_W'(up) + SUM_W'(down);
		diff = gain - ring;
		if (diff[SUM_W-1]) begin
			clamped = '0;
		end else if (diff[SUM_W-2:CHAN_W] != '0) begin
			clamped = '1;
		end else begin
			clamped = diff[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sharp_s2 <= clamped;
		end
	end

endmodule

### rtl/cks_merge.sv
`timescale 1ns / 1ps

module cks_merge
	import cks_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s2,
	input  cks_res_t               res_s2,
	input  logic [PX_W-1:0]        sharp_s2,
	output logic                   out_en,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam int PAD_W = OUT_TDATA_W - PX_W - ROW_W - COL_W;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_last_q;
	logic [PX_W-1:0]        px;

	assign out_en = !out_valid_q || m_tready;
	assign px     = res_s2.sharp ? sharp_s2 : res_s2.pass_px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			out_data_q <= {PAD_W'(0), res_s2.col, res_s2.row, px};
			out_last_q <= res_s2.eof;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### rtl/cross_kernel_sharpen_rgb.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: blue, green, red; tuser: start_of_frame, flush
// m_        out  m_tvalid/m_tready  tdata: blue, green, red, row, col; tlast: end_of_frame
// cfg_      in   cfg_we             cfg_idx, cfg_wdata (line_width, frame_height)
//
// One item per clock unless m_ stalls. A result passes through stage 1, stage 2 and the output register.
// Results trail pixels by line_width + 1 items; flush items drain the last of them.
// The line store has one read and one write port; same-address reads are forwarded.
// Reset clears counters, window and pipeline; the line store holds no reset state.
// A stalled m_ side backs up through the pipeline to s_tready.

module cross_kernel_sharpen_rgb
	import cks_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PX_W-1:0]        s_tdata,  // blue, green, red
	input  logic [TUSER_W-1:0]     s_tuser,  // start_of_frame, flush
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // blue, green, red, out_row, out_col, pad
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	logic [CFG_W-1:0]  lw_q;
	logic [CFG_W-1:0]  fh_q;
	logic [CFG_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic [ADDR_W-1:0] wm1;
	logic [ROW_W-1:0]  hm1;

	logic [ROW_W-1:0]  in_row_q, in_row_d;
	logic [ADDR_W-1:0] in_col_q, in_col_d;
	logic [ROW_W-1:0]  out_row_q, out_row_d;
	logic [ADDR_W-1:0] out_col_q, out_col_d;

	logic              acc;
	logic              sof;
	logic              fl;
	logic [ROW_W-1:0]  r0;
	logic [ADDR_W-1:0] c0;
	logic              take;
	logic              pix_d;
	logic              emit_d;
	cks_src_t          src_d;
	logic [ROW_W-1:0]  row_d;
	logic [ADDR_W-1:0] col_d;
	logic              eof_d;
	logic [ADDR_W-1:0] addr_d;

	logic              valid_s1;
	logic              pix_s1;
	logic              emit_s1;
	cks_src_t          src_s1;
	logic [PX_W-1:0]   px_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ADDR_W-1:0] col_s1;
	logic              eof_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic              valid_s2;
	cks_res_t          res_s2;
	logic [PX_W-1:0]   sharp_s2;

	logic              en1, en2, out_en;
	logic [2*PX_W-1:0] rd_data;
	logic [PX_W-1:0]   old_up, old_mid;
	logic              wr_en;
	logic [PX_W-1:0]   pass_px;

	logic [PX_W-1:0]   win1_q, win2_q, win4_q, win5_q, win7_q, win8_q;

	always_comb begin
		if (lw_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (lw_q > CFG_W'(MAX_LINE_WIDTH)) begin
			w_eff = CFG_W'(MAX_LINE_WIDTH);
		end else begin
			w_eff = lw_q;
		end
		h_eff = (fh_q == '0) ? ROW_W'(1) : fh_q;
		wm1   = ADDR_W'(w_eff - CFG_W'(1));
		hm1   = h_eff - ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= LINE_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LINE_WIDTH:   lw_q <= cfg_wdata;
				REG_FRAME_HEIGHT: fh_q <= cfg_wdata;
				default:          lw_q <= lw_q;
			endcase
		end
	end

	// accept decode
	assign acc = s_tvalid && s_tready;
	assign sof = s_tuser[TUSER_SOF];
	assign fl  = s_tuser[TUSER_FLUSH];
	assign r0  = sof ? '0 : in_row_q;
	assign c0  = sof ? '0 : in_col_q;

	always_comb begin
		in_row_d  = in_row_q;
		in_col_d  = in_col_q;
		out_row_d = out_row_q;
		out_col_d = out_col_q;
		take      = 1'b0;
		pix_d     = 1'b0;
		emit_d    = 1'b0;
		src_d     = SRC_WINDOW;
		row_d     = out_row_q;
		col_d     = out_col_q;
		eof_d     = 1'b0;
		addr_d    = out_col_q;
		if (fl) begin
			if (in_row_q >= h_eff && out_row_q < h_eff) begin
				take   = 1'b1;
				emit_d = 1'b1;
				src_d  = (out_row_q == hm1) ? SRC_MID : SRC_UP;
				eof_d  = (out_row_q == hm1) && (out_col_q == wm1);
				if (out_col_q == wm1) begin
					out_col_d = '0;
					out_row_d = out_row_q + ROW_W'(1);
				end else begin
					out_col_d = out_col_q + ADDR_W'(1);
				end
			end
		end else begin
			if (sof) begin
				out_row_d = '0;
				out_col_d = '0;
				in_row_d  = '0;
				in_col_d  = '0;
			end
			if (r0 < h_eff) begin
				take   = 1'b1;
				pix_d  = 1'b1;
				addr_d = c0;
				if (c0 == '0 && r0 >= ROW_W'(2)) begin
					emit_d    = 1'b1;
					src_d     = SRC_WINDOW;
					row_d     = r0 - ROW_W'(2);
					col_d     = wm1;
					out_row_d = r0 - ROW_W'(1);
					out_col_d = '0;
				end else if (c0 != '0 && r0 >= ROW_W'(1)) begin
					emit_d    = 1'b1;
					src_d     = (r0 == ROW_W'(1) || c0 == ADDR_W'(1)) ? SRC_WINDOW : SRC_SHARP;
					row_d     = r0 - ROW_W'(1);
					col_d     = c0 - ADDR_W'(1);
					out_row_d = r0 - ROW_W'(1);
					out_col_d = c0;
				end
				if (c0 == wm1) begin
					in_col_d = '0;
					in_row_d = r0 + ROW_W'(1);
				end else begin
					in_col_d = c0 + ADDR_W'(1);
					in_row_d = r0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (acc) begin
			in_row_q  <= in_row_d;
			in_col_q  <= in_col_d;
			out_row_q <= out_row_d;
			out_col_q <= out_col_d;
		end
	end

	// pipeline control
	assign en2      = !valid_s2 || out_en;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= acc && take;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1  <= pix_d;
			emit_s1 <= emit_d;
			src_s1  <= src_d;
			px_s1   <= s_tdata;
			row_s1  <= row_d;
			col_s1  <= col_d;
			eof_s1  <= eof_d;
			addr_s1 <= addr_d;
		end
	end

	cks_line_store u_store (
		.clk     (clk),
		.rd_en   (en1),
		.rd_addr (addr_d),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data ({px_s1, old_mid}),
		.rd_data (rd_data)
	);

	assign old_up  = rd_data[PX_W-1:0];
	assign old_mid = rd_data[2*PX_W-1:PX_W];
	assign wr_en   = valid_s1 && pix_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win1_q <= '0;
			win2_q <= '0;
			win4_q <= '0;
			win5_q <= '0;
			win7_q <= '0;
			win8_q <= '0;
		end else if (wr_en) begin
			win1_q <= win2_q;
			win2_q <= old_up;
			win4_q <= win5_q;
			win5_q <= old_mid;
			win7_q <= win8_q;
			win8_q <= px_s1;
		end
	end

	always_comb begin
		unique case (src_s1)
			SRC_UP:  pass_px = old_up;
			SRC_MID: pass_px = old_mid;
			default: pass_px = win5_q;
		endcase
	end

	// one lane per colour channel
	for (genvar k = 0; k < PIXEL_CHANNELS; k++) begin : g_lane
		cks_lane u_lane (
			.clk      (clk),
			.en       (en2),
			.centre   (win5_q[k*CHAN_W +: CHAN_W]),
			.left     (win4_q[k*CHAN_W +: CHAN_W]),
			.right    (old_mid[k*CHAN_W +: CHAN_W]),
			.up       (win2_q[k*CHAN_W +: CHAN_W]),
			.down     (win8_q[k*CHAN_W +: CHAN_W]),
			.sharp_s2 (sharp_s2[k*CHAN_W +: CHAN_W])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			res_s2.sharp   <= (src_s1 == SRC_SHARP);
			res_s2.pass_px <= pass_px;
			res_s2.row     <= row_s1;
			res_s2.col     <= COL_W'(col_s1);
			res_s2.eof     <= eof_s1;
		end
	end

	cks_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.res_s2   (res_s2),
		.sharp_s2 (sharp_s2),
		.out_en   (out_en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= wm1)
		else $error("input column beyond line width");

	a_out_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_col_q <= wm1)
		else $error("output column beyond line width");

	a_in_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= h_eff)
		else $error("input row beyond frame height");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en2 |=> valid_s1 && $stable(px_s1) && $stable(addr_s1))
		else $error("stage 1 item lost under stall");

	a_eof_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[PX_W +: ROW_W] == hm1)
		else $error("end of frame off the last row");
`endif

endmodule

### dv/cross_kernel_sharpen_rgb_test.sv
`timescale 1ns / 1ps

module cross_kernel_sharpen_rgb_test;
	import cks_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 560;
	localparam int CALM_ITEMS     = 480;

	// directed frame pixels
	localparam logic [PX_W-1:0] PX_CORNER = 24'h80ff00;
	localparam logic [PX_W-1:0] PX_NBR    = 24'h14ff00;
	localparam logic [PX_W-1:0] PX_CTR    = 24'h3c00ff;
	localparam logic [PX_W-1:0] PX_WHITE  = 24'hffffff;
	localparam logic [PX_W-1:0] PX_BLACK  = 24'h000000;
	localparam logic [PX_W-1:0] PX_LAST   = 24'h5aa5c3;
	localparam logic [PX_W-1:0] PX_RESTART = 24'h010203;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              eof;
	} pix_res_t;

	typedef enum logic [1:0] {ROW_PIX, ROW_FLUSH, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_FIXED} exp_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             sof;
		logic [PX_W-1:0]  px;
		logic             cfg_sel;
		logic [CFG_W-1:0] cfg_val;
		exp_kind_t        chk;
		pix_res_t         want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [PX_W-1:0]        s_tdata;   // blue, green, red
	logic [TUSER_W-1:0]     s_tuser;   // start_of_frame, flush
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // blue, green, red, out_row, out_col, pad
	logic                   m_tlast;
	logic                   cfg_we;
	logic                   cfg_idx;
	logic [CFG_W-1:0]       cfg_wdata;

	// predictor state
	logic [CFG_W-1:0] lw_reg;
	logic [CFG_W-1:0] fh_reg;
	logic [PX_W-1:0]  up_line [MAX_LINE_WIDTH];
	logic [PX_W-1:0]  mid_line [MAX_LINE_WIDTH];
	logic [PX_W-1:0]  win [9];
	int unsigned      row_cnt;
	int unsigned      col_cnt;
	int unsigned      out_pos;

	pix_res_t    pending_pixels [$];
	stim_row_t   stim_rows [$];
	int unsigned bad_pixels;
	int unsigned items_used;
	int unsigned idle_cycles;
	int          gap_pct;
	int          stall_left;
	bit          stall_mode;
	bit          calm;

	cross_kernel_sharpen_rgb dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_w();
		if (lw_reg == 0) return 1;
		if (lw_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
		return lw_reg;
	endfunction

	function automatic int unsigned eff_h();
		return (fh_reg == 0) ? 1 : fh_reg;
	endfunction

	function automatic pix_res_t res_of(logic [PX_W-1:0] px, int unsigned row,
			int unsigned col, logic eof);
		pix_res_t res;
		res.blue  = px[7:0];
		res.green = px[15:8];
		res.red   = px[23:16];
		res.row   = row[ROW_W-1:0];
		res.col   = col[COL_W-1:0];
		res.eof   = eof;
		return res;
	endfunction

	function automatic pix_res_t emit_res(logic [PX_W-1:0] px, int unsigned row,
			int unsigned col, int unsigned total);
		pix_res_t res;
		res = res_of(px, row, col, out_pos + 1 == total);
		out_pos = out_pos + 1;
		return res;
	endfunction

	function automatic logic [PX_W-1:0] sharpened_px();
		logic [PX_W-1:0] res;
		int              v, ctr, lf, rt, up, dn;
		res = '0;
		for (int k = 0; k < PIXEL_CHANNELS; k++) begin
			ctr = win[4][CHAN_W*k +: CHAN_W];
			lf  = win[3][CHAN_W*k +: CHAN_W];
			rt  = win[5][CHAN_W*k +: CHAN_W];
			up  = win[1][CHAN_W*k +: CHAN_W];
			dn  = win[7][CHAN_W*k +: CHAN_W];
			v = SHARP_GAIN * ctr - lf - rt - up - dn;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			res[CHAN_W*k +: CHAN_W] = v[CHAN_W-1:0];
		end
		return res;
	endfunction

	// returns 1 if the item was not ignored
	function automatic bit sharpen_predict(logic sof, logic flush, logic [PX_W-1:0] px,
			output bit has_res, output pix_res_t res);
		int unsigned     w, h, total, r, c, qr, qc;
		logic [PX_W-1:0] pre, old_up, old_mid, val;
		bit              border;
		has_res = 1'b0;
		res = '0;
		w = eff_w();
		h = eff_h();
		total = w * h;
		if (flush) begin
			if (row_cnt < h || out_pos >= total) return 1'b0;
			qr = out_pos / w;
			qc = out_pos - qr * w;
			val = (qr + 1 >= h) ? mid_line[qc] : up_line[qc];
			res = emit_res(val, qr, qc, total);
			has_res = 1'b1;
			return 1'b1;
		end
		if (sof) begin
			row_cnt = 0;
			col_cnt = 0;
			out_pos = 0;
		end
		if (row_cnt >= h) return 1'b0;
		r = row_cnt;
		c = col_cnt;
		if (c >= w) c = 0;
		pre = win[5];
		old_up = up_line[c];
		old_mid = mid_line[c];
		up_line[c] = old_mid;
		mid_line[c] = px;
		win[0] = win[1]; win[1] = win[2]; win[2] = old_up;
		win[3] = win[4]; win[4] = win[5]; win[5] = old_mid;
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		if (c == 0) begin
			if (r >= 2) begin
				out_pos = (r - 1) * w - 1;
				res = emit_res(pre, r - 2, w - 1, total);
				has_res = 1'b1;
			end
		end else if (r >= 1) begin
			qr = r - 1;
			qc = c - 1;
			border = qr == 0 || qc == 0 || qr + 1 >= h || qc + 1 >= w;
			val = border ? win[4] : sharpened_px();
			out_pos = qr * w + qc;
			res = emit_res(val, qr, qc, total);
			has_res = 1'b1;
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t item_row(row_kind_t kind, logic sof, logic [PX_W-1:0] px,
			exp_kind_t chk, pix_res_t want);
		stim_row_t row;
		row = '0;
		row.kind = kind;
		row.sof  = sof;
		row.px   = px;
		row.chk  = chk;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic sel, logic [CFG_W-1:0] val);
		stim_row_t row;
		row = '0;
		row.kind    = ROW_CFG;
		row.cfg_sel = sel;
		row.cfg_val = val;
		row.chk     = EXP_NONE;
		return row;
	endfunction

	function automatic logic [PX_W-1:0] rand_px();
		logic [PX_W-1:0] px;
		for (int k = 0; k < PIXEL_CHANNELS; k++) begin
			if ($urandom_range(0, 3) == 0)
				px[CHAN_W*k +: CHAN_W] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			else
				px[CHAN_W*k +: CHAN_W] = CHAN_W'($urandom_range(0, 255));
		end
		return px;
	endfunction

	task automatic report_bad(string what, pix_res_t want, pix_res_t seen);
		bad_pixels++;
		if (bad_pixels <= 10)
			$display({"%0t %s: exp b%0d g%0d r%0d row%0d col%0d eof%0d,",
				" got b%0d g%0d r%0d row%0d col%0d eof%0d"},
				$time, what, want.blue, want.green, want.red, want.row, want.col, want.eof,
				seen.blue, seen.green, seen.red, seen.row, seen.col, seen.eof);
	endtask

	task automatic drive_item(logic sof, logic flush, logic [PX_W-1:0] px);
		logic [TUSER_W-1:0] u;
		u = '0;
		u[TUSER_SOF]   = sof;
		u[TUSER_FLUSH] = flush;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= u;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic feed(logic sof, logic flush, logic [PX_W-1:0] px);
		bit       got;
		pix_res_t res;
		drive_item(sof, flush, px);
		if (sharpen_predict(sof, flush, px, got, res)) items_used++;
		if (got) pending_pixels.push_back(res);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_pixels.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic sel, logic [CFG_W-1:0] val);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= sel;
		cfg_wdata <= val;
		@(posedge clk);
		if (sel == REG_LINE_WIDTH) lw_reg = val;
		else fh_reg = val;
		row_cnt = 0;
		col_cnt = 0;
		out_pos = 0;
		cfg_we <= 1'b0;
	endtask

	task automatic play_frame(bit noisy);
		int unsigned w, h, n, k;
		w = eff_w();
		h = eff_h();
		n = w * h;
		gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
		// aborted start, restarted below
		if (noisy && $urandom_range(0, 9) == 0) begin
			k = $urandom_range(1, n);
			for (int i = 0; i < k; i++) feed(i == 0, 1'b0, rand_px());
		end
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				feed(1'($urandom_range(0, 1)), 1'b1, rand_px());
			if (noisy && i == n / 2 && $urandom_range(0, 7) == 0) wait_drained();
			feed(i == 0, 1'b0, rand_px());
		end
		for (int j = 0; j <= w + $urandom_range(0, 2); j++) begin
			if (noisy && $urandom_range(0, 9) == 0) feed(1'b0, 1'b0, rand_px());
			feed(1'($urandom_range(0, 1)), 1'b1, rand_px());
		end
	endtask

	// result side stalls
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		stall_mode = 1'b1;
		forever begin
			@(posedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (stall_mode && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
		end
	end

	always @(posedge clk) begin : result_check
		pix_res_t seen, want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.blue  = m_tdata[7:0];
			seen.green = m_tdata[15:8];
			seen.red   = m_tdata[23:16];
			seen.row   = m_tdata[PX_W +: ROW_W];
			seen.col   = m_tdata[PX_W+ROW_W +: COL_W];
			seen.eof   = m_tlast;
			if (pending_pixels.size() == 0) begin
				report_bad("unexpected item", '0, seen);
			end else begin
				want = pending_pixels.pop_front();
				if (seen.blue !== want.blue || seen.green !== want.green
						|| seen.red !== want.red || seen.row !== want.row
						|| seen.col !== want.col || seen.eof !== want.eof)
					report_bad("mismatch", want, seen);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int unsigned w, h, sel;
		bit          got, first;
		pix_res_t    res;
		stim_row_t   row;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_LINE_WIDTH;
		cfg_wdata = '0;
		calm      = 1'b0;
		gap_pct   = 25;
		bad_pixels = 0;
		items_used = 0;
		lw_reg = LINE_WIDTH_RST;
		fh_reg = FRAME_HEIGHT_RST;
		for (int i = 0; i < MAX_LINE_WIDTH; i++) begin
			up_line[i]  = '0;
			mid_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;
		row_cnt = 0;
		col_cnt = 0;
		out_pos = 0;

		// 3x3 frame: border pass-through, one sharpened centre, flush drain
		stim_rows.push_back(cfg_row(REG_LINE_WIDTH, 12'd3));
		stim_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 12'd3));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_WHITE, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b1, PX_CORNER, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_NBR, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_WHITE, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_NBR, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_CTR, EXP_FIXED,
			res_of(PX_CORNER, 0, 0, 1'b0)));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_NBR, EXP_FIXED,
			res_of(PX_NBR, 0, 1, 1'b0)));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_BLACK, EXP_FIXED,
			res_of(PX_WHITE, 0, 2, 1'b0)));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_NBR, EXP_FIXED,
			res_of(PX_NBR, 1, 0, 1'b0)));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_LAST, EXP_MODEL, '0));
		// flush wins over start_of_frame
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b1, PX_WHITE, EXP_FIXED,
			res_of(PX_NBR, 1, 2, 1'b0)));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_BLACK, EXP_FIXED,
			res_of(PX_BLACK, 2, 0, 1'b0)));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_BLACK, EXP_FIXED,
			res_of(PX_NBR, 2, 1, 1'b0)));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_BLACK, EXP_FIXED,
			res_of(PX_LAST, 2, 2, 1'b1)));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_BLACK, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_WHITE, EXP_NONE, '0));
		// restart part way through a frame
		stim_rows.push_back(item_row(ROW_PIX, 1'b1, PX_RESTART, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_WHITE, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_BLACK, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_LAST, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_PIX, 1'b0, PX_CTR, EXP_FIXED,
			res_of(PX_RESTART, 0, 0, 1'b0)));
		stim_rows.push_back(item_row(ROW_PIX, 1'b1, PX_NBR, EXP_NONE, '0));
		stim_rows.push_back(item_row(ROW_FLUSH, 1'b0, PX_NBR, EXP_NONE, '0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset sizes, no start_of_frame: first result of the frame
		for (int i = 0; i < LINE_WIDTH_RST + 2; i++) feed(1'b0, 1'b0, rand_px());

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CFG) begin
				write_reg(row.cfg_sel, row.cfg_val);
			end else begin
				drive_item(row.sof, row.kind == ROW_FLUSH, row.px);
				void'(sharpen_predict(row.sof, row.kind == ROW_FLUSH, row.px, got, res));
				if (row.chk == EXP_FIXED) pending_pixels.push_back(row.want);
				else if (row.chk == EXP_MODEL && got) pending_pixels.push_back(res);
			end
		end

		// size extremes, including out-of-range register values
		write_reg(REG_LINE_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, 12'd4095);
		for (int i = 0; i < 12; i++) feed(i == 0, 1'b0, rand_px());
		write_reg(REG_LINE_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		play_frame(1'b0);

		items_used = 0;
		first = 1'b1;
		while (items_used < RANDOM_ITEMS) begin
			if (items_used >= CALM_ITEMS) calm = 1'b1;
			if (first || $urandom_range(0, 2) == 0) begin
				sel = $urandom_range(0, 19);
				if (sel < 14) begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 6);
				end else if (sel < 19) begin
					w = $urandom_range(9, 40);
					h = $urandom_range(2, 10);
				end else begin
					w = $urandom_range(41, 160);
					h = $urandom_range(2, 3);
				end
				if (first || $urandom_range(0, 1)) write_reg(REG_LINE_WIDTH, CFG_W'(w));
				if (first || $urandom_range(0, 1)) write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
				first = 1'b0;
			end
			play_frame(1'b1);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (bad_pixels == 0 && pending_pixels.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d bad items, %0d never arrived", bad_pixels, pending_pixels.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
